[design/iir_filter_order17_defines.svh]
// Assertion macros shared by the filter modules.
// Each check is clocked on i_clk and switched off while i_rst_n is low.
`ifndef IIR_FILTER_ORDER17_DEFINES_SVH
`define IIR_FILTER_ORDER17_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication
`define IIR17_ASSERT_HOLD(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define IIR17_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define IIR17_ASSERT_HOLD(lbl, ante, cons, msg)

`define IIR17_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[design/iir17_pkg.sv]
package iir17_pkg;

    // Fixed-point format of coefficients and past outputs: signed Q15.48
    localparam int COEF_W    = 64;
    localparam int HALF_W    = 32;
    localparam int Q_FRAC    = 48;
    // Shared multiplier: 33 x 33 signed, one half-word of each operand
    localparam int MUL_W     = HALF_W + 1;
    localparam int PP_W      = 2 * MUL_W;
    localparam int PROD_W    = 2 * COEF_W;
    // Coefficient ROM
    localparam int ROM_SLOTS = 32;
    localparam int ROM_IDX_W = 5;
    // Cycles between the last multiply issue and the accumulator settling
    localparam int DRAIN_CYCLES = 3;

    // Partial-product codes: which half of the coefficient (C) and of the
    // data operand (B) go through the multiplier. Bit 0 selects the upper
    // coefficient half, bit 1 the upper data half.
    localparam logic [1:0] PART_CLO_BLO = 2'd0;
    localparam logic [1:0] PART_CHI_BLO = 2'd1;
    localparam logic [1:0] PART_CLO_BHI = 2'd2;
    localparam logic [1:0] PART_CHI_BHI = 2'd3;

    // One multiply issue from the sequencer to the datapath
    typedef struct packed {
        logic                 valid;
        logic                 den;
        logic [1:0]           part;
        logic                 tap_ok;
        logic [ROM_IDX_W-1:0] coef_idx;
    } t_mac_op;

    // Powers of ten for the coefficient conversion
    localparam logic [127:0] P9  = 128'd1000000000;
    localparam logic [127:0] P10 = 128'd10000000000;
    localparam logic [127:0] P11 = 128'd100000000000;
    localparam logic [127:0] P13 = 128'd10000000000000;
    localparam logic [127:0] P14 = 128'd100000000000000;
    localparam logic [127:0] P15 = 128'd1000000000000000;
    localparam logic [127:0] P16 = 128'd10000000000000000;

    // Numerator coefficients, Q15.48, rounded half away from zero
    localparam logic [63:0] NUM_C0 = 64'(((128'd1539807224874 << Q_FRAC) + (P16 >> 1)) / P16);
    localparam logic [63:0] NUM_C1 = 64'(-(((128'd1633551718237 << Q_FRAC) + (P15 >> 1)) / P15));
    localparam logic [63:0] NUM_C2 = 64'(((128'd8285871521075 << Q_FRAC) + (P15 >> 1)) / P15);
    localparam logic [63:0] NUM_C3 = 64'(-(((128'd2655137141783 << Q_FRAC) + (P14 >> 1)) / P14));
    localparam logic [63:0] NUM_C4 = 64'(((128'd5976268341326 << Q_FRAC) + (P14 >> 1)) / P14);
    localparam logic [63:0] NUM_C5 = 64'(-(((128'd9892004512411 << Q_FRAC) + (P14 >> 1)) / P14));
    localparam logic [63:0] NUM_C6 = 64'(((128'd1209510267949 << Q_FRAC) + (P13 >> 1)) / P13);
    localparam logic [63:0] NUM_C7 = 64'(-(((128'd1024952672175 << Q_FRAC) + (P13 >> 1)) / P13));
    localparam logic [63:0] NUM_C8 = 64'(((128'd4044670396161 << Q_FRAC) + (P14 >> 1)) / P14);

    // Denominator coefficients, leading 1 implied
    localparam logic [63:0] DEN_C1  = 64'(-(((128'd1283384996104 << Q_FRAC) + (P11 >> 1)) / P11));
    localparam logic [63:0] DEN_C2  = 64'(((128'd7793650732675 << Q_FRAC) + (P11 >> 1)) / P11);
    localparam logic [63:0] DEN_C3  = 64'(-(((128'd2973335694968 << Q_FRAC) + (P10 >> 1)) / P10));
    localparam logic [63:0] DEN_C4  = 64'(((128'd7979129616887 << Q_FRAC) + (P10 >> 1)) / P10);
    localparam logic [63:0] DEN_C5  = 64'(-(((128'd1597972651706 << Q_FRAC) + (P9 >> 1)) / P9));
    localparam logic [63:0] DEN_C6  = 64'(((128'd2472494945198 << Q_FRAC) + (P9 >> 1)) / P9);
    localparam logic [63:0] DEN_C7  = 64'(-(((128'd3018357074163 << Q_FRAC) + (P9 >> 1)) / P9));
    localparam logic [63:0] DEN_C8  = 64'(((128'd2942681165509 << Q_FRAC) + (P9 >> 1)) / P9);
    localparam logic [63:0] DEN_C9  = 64'(-(((128'd2303842335957 << Q_FRAC) + (P9 >> 1)) / P9));
    localparam logic [63:0] DEN_C10 = 64'(((128'd1448206814835 << Q_FRAC) + (P9 >> 1)) / P9);
    localparam logic [63:0] DEN_C11 = 64'(-(((128'd7266729407251 << Q_FRAC) + (P10 >> 1)) / P10));
    localparam logic [63:0] DEN_C12 = 64'(((128'd2874544421962 << Q_FRAC) + (P10 >> 1)) / P10);
    localparam logic [63:0] DEN_C13 = 64'(-(((128'd8775235536838 << Q_FRAC) + (P11 >> 1)) / P11));
    localparam logic [63:0] DEN_C14 = 64'(((128'd1996212762001 << Q_FRAC) + (P11 >> 1)) / P11);
    localparam logic [63:0] DEN_C15 = 64'(-(((128'd3188300212 << Q_FRAC) + (P9 >> 1)) / P9));
    localparam logic [63:0] DEN_C16 = 64'(((128'd3191936459711 << Q_FRAC) + (P13 >> 1)) / P13);
    localparam logic [63:0] DEN_C17 = 64'(-(((128'd1508036852769 << Q_FRAC) + (P14 >> 1)) / P14));

    // Numerator ROM is symmetric; unused slots read as zero
    localparam logic [63:0] NUM_ROM [ROM_SLOTS] = '{
        0: NUM_C0,  1: NUM_C1,  2: NUM_C2,  3: NUM_C3,  4: NUM_C4,  5: NUM_C5,
        6: NUM_C6,  7: NUM_C7,  8: NUM_C8,  9: NUM_C8, 10: NUM_C7, 11: NUM_C6,
        12: NUM_C5, 13: NUM_C4, 14: NUM_C3, 15: NUM_C2, 16: NUM_C1, 17: NUM_C0,
        default: 64'd0
    };

    localparam logic [63:0] DEN_ROM [ROM_SLOTS] = '{
        1: DEN_C1,   2: DEN_C2,   3: DEN_C3,   4: DEN_C4,   5: DEN_C5,   6: DEN_C6,
        7: DEN_C7,   8: DEN_C8,   9: DEN_C9,  10: DEN_C10, 11: DEN_C11, 12: DEN_C12,
        13: DEN_C13, 14: DEN_C14, 15: DEN_C15, 16: DEN_C16, 17: DEN_C17,
        default: 64'd0
    };

endpackage

[design/iir17_ram.sv]
module iir17_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 18
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/iir17_mac.sv]
`include "iir_filter_order17_defines.svh"

module iir17_mac
    import iir17_pkg::*;
#(
    parameter int TAPS        = 18,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clear,
    input  t_mac_op                       i_op,
    input  logic signed [SAMPLE_BITS-1:0] i_x_data,
    input  logic [COEF_W-1:0]             i_y_data,
    output logic [SAMPLE_BITS-1:0]        o_sample,
    output logic                          o_clip,
    output logic [COEF_W-1:0]             o_y_new
);

    // Accumulator sized for the worst-case sum of all terms
    localparam int NUM_BITS = SAMPLE_BITS + COEF_W - 2;
    localparam int DEN_BITS = 2 * COEF_W - 2 - Q_FRAC;
    localparam int ACC_W    = ((NUM_BITS > DEN_BITS) ? NUM_BITS : DEN_BITS) + $clog2(TAPS) + 2;
    localparam int RW       = ACC_W - Q_FRAC;

    localparam logic [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [COEF_W-1:0]      YMAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic [COEF_W-1:0]      YMIN = {1'b1, {(COEF_W-1){1'b0}}};
    localparam logic [ACC_W-1:0]       RND_HALF = ACC_W'(1) << (Q_FRAC - 1);

    t_mac_op                   r_s1;
    t_mac_op                   r_s2;
    logic                      r_s3_valid;
    logic                      r_s3_den;
    logic [COEF_W-1:0]         r_coef;
    logic signed [PP_W-1:0]    r_pp;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;

    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic signed [PP_W-1:0]    mul_p;
    logic signed [PROD_W-1:0]  pp_ext;
    logic signed [PROD_W-1:0]  pp_shift;
    logic signed [PROD_W-1:0]  n_prod;
    logic                      s2_last;
    logic signed [PROD_W-1:0]  prod_q;
    logic signed [ACC_W-1:0]   n_acc;
    logic [ACC_W-1:0]          acc_rnd;
    logic [RW-1:0]             rq;
    logic                      s_in_range;
    logic                      y_fits;

    // Stage 1: operand halves into the shared multiplier
    always_comb begin
        mul_a = r_s1.part[0] ? {r_coef[COEF_W-1], r_coef[COEF_W-1:HALF_W]}
                             : {1'b0, r_coef[HALF_W-1:0]};
        if (!r_s1.tap_ok) begin
            mul_b = '0;
        end else if (r_s1.den) begin
            mul_b = r_s1.part[1] ? {i_y_data[COEF_W-1], i_y_data[COEF_W-1:HALF_W]}
                                 : {1'b0, i_y_data[HALF_W-1:0]};
        end else begin
            mul_b = MUL_W'(i_x_data);
        end
        mul_p = mul_a * mul_b;
    end

    // Stage 2: place the partial product and build the full product
    always_comb begin
        pp_ext = PROD_W'(r_pp);
        unique case (r_s2.part)
            PART_CLO_BLO: pp_shift = pp_ext;
            PART_CHI_BLO: pp_shift = pp_ext <<< HALF_W;
            PART_CLO_BHI: pp_shift = pp_ext <<< HALF_W;
            PART_CHI_BHI: pp_shift = pp_ext <<< COEF_W;
            default:      pp_shift = pp_ext;
        endcase
        n_prod  = ((r_s2.part == PART_CLO_BLO) ? PROD_W'(0) : r_prod) + pp_shift;
        s2_last = r_s2.den ? (r_s2.part == PART_CHI_BHI) : (r_s2.part == PART_CHI_BLO);
    end

    // Stage 3: numerator products add exactly, feedback products floor to Q.48
    always_comb begin
        prod_q = r_prod >>> Q_FRAC;
        n_acc  = r_s3_den ? (r_acc - ACC_W'(prod_q)) : (r_acc + ACC_W'(r_prod));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1       <= '0;
            r_s2       <= '0;
            r_s3_valid <= 1'b0;
            r_s3_den   <= 1'b0;
        end else begin
            r_s1       <= i_op;
            r_s2       <= r_s1;
            r_s3_valid <= r_s2.valid && s2_last;
            r_s3_den   <= r_s2.den;
        end
        // Datapath registers
        r_coef <= i_op.den ? DEN_ROM[i_op.coef_idx] : NUM_ROM[i_op.coef_idx];
        r_pp   <= mul_p;
        if (r_s2.valid) begin
            r_prod <= n_prod;
        end
        if (i_clear) begin
            r_acc <= '0;
        end else if (r_s3_valid) begin
            r_acc <= n_acc;
        end
    end

    // Round to nearest (ties up) and clamp to the sample range
    always_comb begin
        acc_rnd    = r_acc + RND_HALF;
        rq         = acc_rnd[ACC_W-1:Q_FRAC];
        s_in_range = (&rq[RW-1:SAMPLE_BITS-1]) || !(|rq[RW-1:SAMPLE_BITS-1]);
        o_clip     = !s_in_range;
        if (s_in_range) begin
            o_sample = rq[SAMPLE_BITS-1:0];
        end else begin
            o_sample = rq[RW-1] ? SMIN : SMAX;
        end
    end

    // Stored feedback value saturates to Q15.48
    always_comb begin
        y_fits = (&r_acc[ACC_W-1:COEF_W-1]) || !(|r_acc[ACC_W-1:COEF_W-1]);
        if (y_fits) begin
            o_y_new = r_acc[COEF_W-1:0];
        end else begin
            o_y_new = r_acc[ACC_W-1] ? YMIN : YMAX;
        end
    end

    `IIR17_ASSERT_HOLD(a_no_clear_in_flight, r_s2.valid || r_s3_valid, !i_clear, "acc cleared with products in flight")
    `IIR17_ASSERT_NEXT(a_part_order, r_s2.valid && !s2_last, r_s2.valid && (r_s2.part == $past(r_s2.part) + 2'd1), "partial products out of order")
    `IIR17_ASSERT_HOLD(a_num_low_data, r_s2.valid && !r_s2.den, (r_s2.part == PART_CLO_BLO) || (r_s2.part == PART_CHI_BLO), "numerator issued an upper data half")

endmodule

[design/iir_filter_order17.sv]
// Direct-form-I IIR filter, 17th order, fixed coefficients in Q15.48.
//
// Input stream (s_axis): one signed sample per transfer in tdata.
// Output stream (m_axis): one filtered sample per input in tdata, with the
// saturation flag in tuser.
//
// Both histories live in single-port-read RAMs used as circular buffers.
// Each item runs 2*TAPS numerator partial products followed by
// 4*(TAPS-1) feedback partial products through one shared 33x33 multiplier,
// one per cycle; this multiplier sets the rate. A new sample is taken only
// after the previous result has been loaded into the output register.
//
// After reset both histories read as zero: fill counters mask entries not
// yet written, so no clearing pass is needed.
// A finished result waits in the output register; a new sample is still
// taken meanwhile, but the next result is held back until the previous one
// has been transferred.
`include "iir_filter_order17_defines.svh"

module iir_filter_order17
    import iir17_pkg::*;
#(
    parameter int TAPS        = 18,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  logic [((SAMPLE_BITS + 7) / 8)*8-1:0] i_s_axis_tdata,  // raw_sample
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    output logic [((SAMPLE_BITS + 7) / 8)*8-1:0] o_m_axis_tdata,  // filtered_sample
    output logic [0:0]                           o_m_axis_tuser   // clipped
);

    localparam int DW  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int TW  = $clog2(TAPS);
    localparam int CW  = TW + 1;
    localparam int DY  = TAPS - 1;
    localparam int AWX = $clog2(TAPS);
    localparam int AWY = (DY > 1) ? $clog2(DY) : 1;
    localparam int XCW = $clog2(TAPS + 1);
    localparam int YCW = $clog2(TAPS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_NUM,
        S_DEN,
        S_DRAIN,
        S_FIN
    } t_state;

    t_state                   r_state;
    logic [TW-1:0]            r_tap;
    logic [1:0]               r_part;
    logic [1:0]               r_drain;
    logic [AWX-1:0]           r_ptr_x;
    logic [AWY-1:0]           r_ptr_y;
    logic [XCW-1:0]           r_cnt_x;
    logic [YCW-1:0]           r_cnt_y;
    logic                     r_out_valid;
    logic [SAMPLE_BITS-1:0]   r_out_data;
    logic                     r_out_clip;

    logic [AWX-1:0]           n_ptr_x;
    logic [AWY-1:0]           n_ptr_y;
    logic                     accept_in;
    logic                     out_free;
    logic                     fin_go;
    logic [CW-1:0]            tap_c;
    logic [CW-1:0]            ytap_c;
    logic [CW-1:0]            ptr_x_c;
    logic [CW-1:0]            ptr_y_c;
    logic [CW-1:0]            addr_x_c;
    logic [CW-1:0]            addr_y_c;
    t_mac_op                  mac_op;
    logic [SAMPLE_BITS-1:0]   x_rdata;
    logic [COEF_W-1:0]        y_rdata;
    logic [SAMPLE_BITS-1:0]   mac_sample;
    logic                     mac_clip;
    logic [COEF_W-1:0]        mac_y_new;

    // Handshake qualifiers
    assign accept_in = i_s_axis_tvalid && (r_state == S_IDLE);
    assign out_free  = !r_out_valid || i_m_axis_tready;
    assign fin_go    = (r_state == S_FIN) && out_free;

    // Circular-buffer pointers advance to the slot of the newest entry
    assign n_ptr_x = (r_ptr_x == AWX'(TAPS - 1)) ? '0 : r_ptr_x + 1'b1;
    assign n_ptr_y = (r_ptr_y == AWY'(DY - 1)) ? '0 : r_ptr_y + 1'b1;

    // Tap k sits k slots behind the newest input; feedback tap k sits k-1 behind the newest stored output
    always_comb begin
        tap_c    = CW'(r_tap);
        ytap_c   = tap_c - 1'b1;
        ptr_x_c  = CW'(r_ptr_x);
        ptr_y_c  = CW'(r_ptr_y);
        addr_x_c = (ptr_x_c >= tap_c) ? (ptr_x_c - tap_c) : (ptr_x_c + CW'(TAPS) - tap_c);
        addr_y_c = (ptr_y_c >= ytap_c) ? (ptr_y_c - ytap_c) : (ptr_y_c + CW'(DY) - ytap_c);
    end

    // Multiply issue; unwritten history entries count as zero
    always_comb begin
        mac_op.valid    = (r_state == S_NUM) || (r_state == S_DEN);
        mac_op.den      = (r_state == S_DEN);
        mac_op.part     = r_part;
        mac_op.tap_ok   = mac_op.den ? (ytap_c < CW'(r_cnt_y)) : (tap_c < CW'(r_cnt_x));
        mac_op.coef_idx = ROM_IDX_W'(r_tap);
    end

    // Sequencer, history pointers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tap       <= '0;
            r_part      <= PART_CLO_BLO;
            r_drain     <= '0;
            r_ptr_x     <= '0;
            r_ptr_y     <= '0;
            r_cnt_x     <= '0;
            r_cnt_y     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept_in) begin
                        r_state <= S_NUM;
                        r_tap   <= '0;
                        r_part  <= PART_CLO_BLO;
                        r_ptr_x <= n_ptr_x;
                        if (r_cnt_x != XCW'(TAPS)) begin
                            r_cnt_x <= r_cnt_x + 1'b1;
                        end
                    end
                end
                S_NUM: begin
                    if (r_part == PART_CHI_BLO) begin
                        r_part <= PART_CLO_BLO;
                        if (r_tap == TW'(TAPS - 1)) begin
                            r_state <= S_DEN;
                            r_tap   <= TW'(1);
                        end else begin
                            r_tap <= r_tap + 1'b1;
                        end
                    end else begin
                        r_part <= PART_CHI_BLO;
                    end
                end
                S_DEN: begin
                    r_part <= r_part + 1'b1;
                    if (r_part == PART_CHI_BHI) begin
                        if (r_tap == TW'(TAPS - 1)) begin
                            r_state <= S_DRAIN;
                            r_drain <= '0;
                        end else begin
                            r_tap <= r_tap + 1'b1;
                        end
                    end
                end
                S_DRAIN: begin
                    if (r_drain == 2'(DRAIN_CYCLES - 1)) begin
                        r_state <= S_FIN;
                    end else begin
                        r_drain <= r_drain + 1'b1;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                        r_ptr_y <= n_ptr_y;
                        if (r_cnt_y != YCW'(DY)) begin
                            r_cnt_y <= r_cnt_y + 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (fin_go) begin
                r_out_valid <= 1'b1;
                r_out_data  <= mac_sample;
                r_out_clip  <= mac_clip;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Input history: written on transfer, read by the numerator pass
    iir17_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (TAPS)
    ) u_x_ram (
        .i_clk   (i_clk),
        .i_we    (accept_in),
        .i_waddr (n_ptr_x),
        .i_wdata (i_s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_raddr (addr_x_c[AWX-1:0]),
        .o_rdata (x_rdata)
    );

    // Output history: written once the result is final, after all its reads
    iir17_ram #(
        .WIDTH (COEF_W),
        .DEPTH (DY)
    ) u_y_ram (
        .i_clk   (i_clk),
        .i_we    (fin_go),
        .i_waddr (n_ptr_y),
        .i_wdata (mac_y_new),
        .i_raddr (addr_y_c[AWY-1:0]),
        .o_rdata (y_rdata)
    );

    iir17_mac #(
        .TAPS        (TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (accept_in),
        .i_op     (mac_op),
        .i_x_data (x_rdata),
        .i_y_data (y_rdata),
        .o_sample (mac_sample),
        .o_clip   (mac_clip),
        .o_y_new  (mac_y_new)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = DW'(r_out_data);
    assign o_m_axis_tuser  = r_out_clip;

    `IIR17_ASSERT_HOLD(a_fill_bound, 1'b1, (r_cnt_x <= XCW'(TAPS)) && (r_cnt_y <= YCW'(DY)), "history fill count beyond depth")
    `IIR17_ASSERT_HOLD(a_load_from_fin, $rose(r_out_valid), $past(r_state == S_FIN), "result loaded outside the final step")
    `IIR17_ASSERT_HOLD(a_den_tap_nonzero, r_state == S_DEN, r_tap != '0, "feedback pass on tap zero")

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    localparam int SAMPLE_W         = 16;
    localparam int NTAPS            = 18;
    localparam int QF               = 48;
    localparam int LONG_HOLD_CYCLES = 800;
    localparam int DRAIN_LIMIT      = 5000;
    localparam int SETTLE_CYCLES    = 250;
    localparam int MAX_PRINTED      = 200;

    localparam logic signed [127:0] Q48_HALF  = 128'sd140737488355328;
    localparam logic signed [127:0] Y_MAX     = 128'sd9223372036854775807;
    localparam logic signed [127:0] Y_MIN     = -128'sd9223372036854775808;
    localparam logic signed [127:0] SMP_MAX   = 128'sd32767;
    localparam logic signed [127:0] SMP_MIN   = -128'sd32768;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       clipped;
    } filter_out_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [SAMPLE_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [SAMPLE_W-1:0] m_tdata;
    logic [0:0]          m_tuser;

    // Filter predictor state
    logic signed [63:0] num_coef [NTAPS];
    logic signed [63:0] den_coef [NTAPS];
    logic signed [63:0] x_hist [NTAPS];
    logic signed [63:0] y_hist [NTAPS-1];

    // Coefficients as mantissa and power of ten
    longint num_mant [NTAPS] = '{
        64'sd1539807224874, -64'sd1633551718237, 64'sd8285871521075, -64'sd2655137141783,
        64'sd5976268341326, -64'sd9892004512411, 64'sd1209510267949, -64'sd1024952672175,
        64'sd4044670396161, 64'sd4044670396161, -64'sd1024952672175, 64'sd1209510267949,
        -64'sd9892004512411, 64'sd5976268341326, -64'sd2655137141783, 64'sd8285871521075,
        -64'sd1633551718237, 64'sd1539807224874
    };
    int num_exp [NTAPS] = '{16, 15, 15, 14, 14, 14, 13, 13, 14, 14, 13, 13, 14, 14, 14, 15,
                            15, 16};
    longint den_mant [NTAPS] = '{
        64'sd0, -64'sd1283384996104, 64'sd7793650732675, -64'sd2973335694968,
        64'sd7979129616887, -64'sd1597972651706, 64'sd2472494945198, -64'sd3018357074163,
        64'sd2942681165509, -64'sd2303842335957, 64'sd1448206814835, -64'sd7266729407251,
        64'sd2874544421962, -64'sd8775235536838, 64'sd1996212762001, -64'sd3188300212,
        64'sd3191936459711, -64'sd1508036852769
    };
    int den_exp [NTAPS] = '{0, 11, 11, 10, 10, 9, 9, 9, 9, 9, 9, 10, 10, 11, 11, 9, 13, 14};

    filter_out_t pending_filtered [$];
    int          mismatch_count;
    int          result_count;
    bit          sender_idle;
    bit          receiver_idle;
    bit          long_hold_req;

    iir_filter_order17 u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),   // raw_sample
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),   // filtered_sample
        .o_m_axis_tuser  (m_tuser)    // clipped
    );

    // 2 ns clock
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Decimal coefficient to Q15.48, rounded half away from zero
    function automatic logic signed [63:0] to_q48(input longint mant, input int exp10);
        logic [127:0] pow10;
        logic [127:0] scaled;
        logic [127:0] quo;
        logic [63:0]  mag;
        int           k;
        pow10 = 128'd1;
        for (k = 0; k < exp10 && k < 16; k++)
            pow10 = pow10 * 128'd10;
        mag    = (mant < 0) ? 64'(-mant) : 64'(mant);
        scaled = ({64'd0, mag} << QF) + (pow10 >> 1);
        quo    = scaled / pow10;
        return (mant < 0) ? -quo[63:0] : quo[63:0];
    endfunction

    task automatic init_filter_model();
        int i;
        for (i = 0; i < NTAPS; i++) begin
            num_coef[i] = to_q48(num_mant[i], num_exp[i]);
            den_coef[i] = to_q48(den_mant[i], den_exp[i]);
            x_hist[i]   = '0;
        end
        for (i = 0; i < NTAPS - 1; i++)
            y_hist[i] = '0;
    endtask

    // One filter step: shift histories, run both sums, round and clamp
    function automatic filter_out_t iir_predict(input logic signed [SAMPLE_W-1:0] smp);
        logic signed [127:0] acc;
        logic signed [127:0] opa;
        logic signed [127:0] opb;
        logic signed [127:0] prod;
        logic signed [127:0] rounded;
        logic signed [63:0]  y_full;
        filter_out_t         res;
        int                  i;
        for (i = NTAPS - 1; i > 0; i--)
            x_hist[i] = x_hist[i-1];
        x_hist[0] = smp;
        acc = '0;
        for (i = 0; i < NTAPS; i++) begin
            opa  = num_coef[i];
            opb  = x_hist[i];
            prod = opa * opb;
            acc  = acc + prod;
        end
        // feedback products are floored back to Q.48
        for (i = 1; i < NTAPS; i++) begin
            opa  = den_coef[i];
            opb  = y_hist[i-1];
            prod = opa * opb;
            acc  = acc - (prod >>> QF);
        end
        if (acc > Y_MAX)
            y_full = Y_MAX[63:0];
        else if (acc < Y_MIN)
            y_full = Y_MIN[63:0];
        else
            y_full = acc[63:0];
        for (i = NTAPS - 2; i > 0; i--)
            y_hist[i] = y_hist[i-1];
        y_hist[0] = y_full;
        // round from the unsaturated sum, ties towards plus infinity
        rounded = (acc + Q48_HALF) >>> QF;
        if (rounded > SMP_MAX) begin
            res.sample  = SMP_MAX[SAMPLE_W-1:0];
            res.clipped = 1'b1;
        end else if (rounded < SMP_MIN) begin
            res.sample  = SMP_MIN[SAMPLE_W-1:0];
            res.clipped = 1'b1;
        end else begin
            res.sample  = rounded[SAMPLE_W-1:0];
            res.clipped = 1'b0;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTED)
            $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    // Idle length: mostly short, occasionally long
    function automatic int idle_length();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 120);
    endfunction

    // Offer one sample; called and returns at a falling edge
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp);
        int gap;
        gap = 0;
        if (sender_idle && $urandom_range(0, 9) < 4)
            gap = idle_length();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_filtered.push_back(iir_predict(smp));
        @(negedge clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] random_sample(
        input logic signed [SAMPLE_W-1:0] prev);
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 5)
            return SAMPLE_W'($urandom);
        if (kind < 8)
            return SAMPLE_W'($signed($urandom_range(0, 511)) - 256);
        if (kind == 8)
            return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        return prev + SAMPLE_W'($signed($urandom_range(0, 64)) - 32);
    endfunction

    task automatic test_field_extremes();
        send_sample(16'sd0);
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_sample(16'sd1);
        send_sample(-16'sd1);
        send_sample(16'sh5555);
        send_sample(16'shaaaa);
    endtask

    // Impulse, full-scale alternation and step: the likeliest route to clipping
    task automatic test_full_scale_patterns();
        int i;
        send_sample(16'sh7fff);
        repeat (5) send_sample(16'sd0);
        for (i = 0; i < 8; i++)
            send_sample(i[0] ? 16'sh8000 : 16'sh7fff);
        repeat (4) send_sample(16'sh7fff);
    endtask

    task automatic test_random_samples(input int count);
        logic signed [SAMPLE_W-1:0] smp;
        int                         i;
        smp = '0;
        for (i = 0; i < count; i++) begin
            smp = random_sample(smp);
            send_sample(smp);
        end
    endtask

    // Output held off for a long stretch while input keeps coming
    task automatic test_output_backpressure();
        logic signed [SAMPLE_W-1:0] smp;
        int                         i;
        smp           = '0;
        sender_idle   = 1'b0;
        long_hold_req = 1'b1;
        for (i = 0; i < 16; i++) begin
            smp = random_sample(smp);
            send_sample(smp);
        end
        sender_idle = 1'b1;
    endtask

    // Output ready: random stalls, plus the long hold on request
    initial begin : drive_output_ready
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left    = LONG_HOLD_CYCLES - 1;
                m_tready     <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (receiver_idle && $urandom_range(0, 9) < 3) begin
                stall_left = idle_length() - 1;
                m_tready  <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Compare each output transfer with the oldest prediction
    always @(posedge clk) begin : check_filtered
        filter_out_t want;
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_filtered.size() == 0) begin
                report_mismatch($sformatf("unexpected output %0d",
                                          $signed(m_tdata)));
            end else begin
                want = pending_filtered.pop_front();
                if (m_tdata !== want.sample)
                    report_mismatch($sformatf("result %0d: sample %0d, want %0d",
                                              result_count, $signed(m_tdata),
                                              want.sample));
                if (m_tuser[0] !== want.clipped)
                    report_mismatch($sformatf("result %0d: clipped %b, want %b",
                                              result_count, m_tuser[0],
                                              want.clipped));
            end
            result_count++;
        end
    end

    initial begin : run_tests
        int waited;
        mismatch_count = 0;
        result_count   = 0;
        sender_idle    = 1'b1;
        receiver_idle  = 1'b1;
        long_hold_req  = 1'b0;
        clk            = 1'b0;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        init_filter_model();
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        test_field_extremes();
        test_full_scale_patterns();
        test_random_samples(450);
        // a stretch with no idling on either side
        sender_idle   = 1'b0;
        receiver_idle = 1'b0;
        test_random_samples(200);
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
        test_output_backpressure();
        test_random_samples(730);
        s_tvalid <= 1'b0;

        // drain what is still in flight
        waited = 0;
        while (pending_filtered.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_filtered.size() != 0)
            report_mismatch($sformatf("%0d filtered samples never arrived",
                                      pending_filtered.size()));
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #6000000;
        $display("status: fail");
        $finish;
    end

endmodule
